>>> rtl/fvp_pkg.sv
// shared types, constants and saturation helper for the filtered velocity pid unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fvp_pkg;

    localparam int DEFAULT_SAMPLE_WIDTH = 16;
    localparam int COEF_W               = 32;
    localparam int PROD_W               = 64;
    localparam int ACC_W                = 48;
    localparam int CFG_IDX_W            = 3;
    localparam int SAMPLE_FRAC          = 8;
    localparam int COEF_FRAC            = 16;

    localparam logic signed [COEF_W-1:0] DRIVE_HIGH_RST = 32'sd6553600;
    localparam logic signed [COEF_W-1:0] DRIVE_LOW_RST  = 32'sd0;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN            = 3'd0,
        CFG_INTEGRAL_COEF   = 3'd1,
        CFG_DERIVATIVE_COEF = 3'd2,
        CFG_FILTER_FEEDBACK = 3'd3,
        CFG_FILTER_INPUT    = 3'd4,
        CFG_DRIVE_HIGH      = 3'd5,
        CFG_DRIVE_LOW       = 3'd6
    } fvp_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FF,
        ST_FI,
        ST_P,
        ST_I,
        ST_D,
        ST_DPOST,
        ST_SUM
    } fvp_state_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_FF,
        MUL_FI,
        MUL_P,
        MUL_I,
        MUL_D
    } fvp_mul_t;

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     mul_en;
        fvp_mul_t mul_op;
        logic     acc_ld;
        logic     f_ld;
        logic     p_ld;
        logic     diff_ld;
        logic     i_ld;
        logic     d_ld;
        logic     commit;
    } fvp_ctrl_t;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COEF_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COEF_W-1:0];
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/fvp_seq.sv
// sequencer: walks one item through the shared multiplier schedule
// depends on fvp_pkg (state enum, control struct)
`timescale 1ns / 1ps

module fvp_seq
    import fvp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output fvp_ctrl_t ctrl
);

    fvp_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctrl         = '0;
        ctrl.mul_op  = MUL_FF;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                ctrl.prep  = 1'b1;
                state_next = ST_FF;
            end
            ST_FF: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_FF;
                state_next  = ST_FI;
            end
            ST_FI: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_FI;
                ctrl.acc_ld = 1'b1;
                state_next  = ST_P;
            end
            ST_P: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_P;
                ctrl.f_ld   = 1'b1;
                state_next  = ST_I;
            end
            ST_I: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = MUL_I;
                ctrl.p_ld    = 1'b1;
                ctrl.diff_ld = 1'b1;
                state_next   = ST_D;
            end
            ST_D: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MUL_D;
                ctrl.i_ld   = 1'b1;
                state_next  = ST_DPOST;
            end
            ST_DPOST: begin
                ctrl.d_ld  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // hold here while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    ctrl.commit  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> rtl/fvp_datapath.sv
// datapath: error operands, shared 32x32 multiplier with product register,
// shift and saturate, filter and drive state; depends on fvp_pkg
`timescale 1ns / 1ps

module fvp_datapath
    import fvp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fvp_ctrl_t                ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0] s_setpoint,
    input  logic                     s_enable,
    input  logic signed [COEF_W-1:0] gain,
    input  logic signed [COEF_W-1:0] integral_coef,
    input  logic signed [COEF_W-1:0] derivative_coef,
    input  logic signed [COEF_W-1:0] filter_feedback,
    input  logic signed [COEF_W-1:0] filter_input,
    input  logic signed [COEF_W-1:0] drive_high,
    input  logic signed [COEF_W-1:0] drive_low,
    output logic signed [COEF_W-1:0] m_drive,
    output logic signed [COEF_W-1:0] m_p_term,
    output logic signed [COEF_W-1:0] m_i_term,
    output logic signed [COEF_W-1:0] m_d_term
);

    localparam int ERR_W = SAMPLE_WIDTH + 1;

    // item and history
    logic signed [ERR_W-1:0]  e_reg, prev_error_reg;
    logic                     en_reg;
    logic signed [COEF_W-1:0] filter_prev_reg, filter_prev2_reg, drive_hold_reg;

    // operands and partial results
    logic signed [COEF_W-1:0] esum_reg, ediff_reg, esat_reg, diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [COEF_W-1:0] f_reg, p_reg, i_reg, d_reg;

    logic signed [COEF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] e_ext, pe_ext;
    logic signed [COEF_W-1:0] sum_sat, drive_next;

    assign e_ext  = PROD_W'(e_reg);
    assign pe_ext = PROD_W'(prev_error_reg);

    always_comb begin
        case (ctrl.mul_op)
            MUL_FF: begin
                mul_a = filter_feedback;
                mul_b = filter_prev_reg;
            end
            MUL_FI: begin
                mul_a = filter_input;
                mul_b = esum_reg;
            end
            MUL_P: begin
                mul_a = gain;
                mul_b = ediff_reg;
            end
            MUL_I: begin
                mul_a = integral_coef;
                mul_b = esat_reg;
            end
            MUL_D: begin
                mul_a = derivative_coef;
                mul_b = diff_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // drive sum and clamp, zero drive before the clamp when disabled
    always_comb begin
        sum_sat = sat32(PROD_W'(drive_hold_reg) + PROD_W'(p_reg)
                        + PROD_W'(i_reg) + PROD_W'(d_reg));
        if (!en_reg) begin
            sum_sat = '0;
        end
        if (sum_sat > drive_high) begin
            drive_next = drive_high;
        end else if (sum_sat < drive_low) begin
            drive_next = drive_low;
        end else begin
            drive_next = sum_sat;
        end
    end

    // history, reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg   <= '0;
            filter_prev_reg  <= '0;
            filter_prev2_reg <= '0;
            drive_hold_reg   <= '0;
        end else if (ctrl.commit) begin
            prev_error_reg   <= e_reg;
            filter_prev2_reg <= filter_prev_reg;
            filter_prev_reg  <= f_reg;
            drive_hold_reg   <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            e_reg  <= ERR_W'(s_setpoint) - ERR_W'(s_measured);
            en_reg <= s_enable;
        end
        if (ctrl.prep) begin
            esum_reg  <= sat32(e_ext + pe_ext);
            ediff_reg <= sat32(e_ext - pe_ext);
            esat_reg  <= sat32(e_ext);
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl.acc_ld) begin
            acc_reg <= ACC_W'(prod_reg >>> COEF_FRAC);
        end
        if (ctrl.f_ld) begin
            f_reg <= sat32(PROD_W'(acc_reg) + (prod_reg >>> SAMPLE_FRAC));
        end
        if (ctrl.p_ld) begin
            p_reg <= en_reg ? sat32(prod_reg >>> SAMPLE_FRAC) : '0;
        end
        if (ctrl.diff_ld) begin
            diff_reg <= sat32(PROD_W'(f_reg) - (PROD_W'(filter_prev_reg) <<< 1)
                              + PROD_W'(filter_prev2_reg));
        end
        if (ctrl.i_ld) begin
            i_reg <= en_reg ? sat32(prod_reg >>> SAMPLE_FRAC) : '0;
        end
        if (ctrl.d_ld) begin
            d_reg <= en_reg ? sat32(prod_reg >>> COEF_FRAC) : '0;
        end
        if (ctrl.commit) begin
            m_drive  <= drive_next;
            m_p_term <= p_reg;
            m_i_term <= i_reg;
            m_d_term <= d_reg;
        end
    end

endmodule

>>> rtl/filtered_velocity_pid_unit.sv
// top level of the filtered velocity pid unit: coefficient registers,
// sequencer and shared-multiplier datapath; depends on fvp_pkg, fvp_seq, fvp_datapath
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_measured, s_setpoint, s_enable
//  m_        out        m_valid / m_ready  m_drive, m_p_term, m_i_term, m_d_term
//  cfg_      in         cfg_wr_en only     cfg_index, cfg_wdata
//
// after acceptance an item holds s_ready low while it runs through one operand prep step,
// five passes through the single 32x32 multiplier, a post step and a sum step.
// reset (aresetn low, synchronous) clears history and m_valid, restores register defaults.
// the result sits in an output register; the next item is accepted while it waits,
// and that item stalls only in its final sum cycle until the output is free.
`timescale 1ns / 1ps

module filtered_velocity_pid_unit
    import fvp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0] s_setpoint,
    input  logic                           s_enable,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [COEF_W-1:0]       m_drive,
    output logic signed [COEF_W-1:0]       m_p_term,
    output logic signed [COEF_W-1:0]       m_i_term,
    output logic signed [COEF_W-1:0]       m_d_term,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [COEF_W-1:0]              cfg_wdata
);

    logic signed [COEF_W-1:0] gain_reg, integral_coef_reg, derivative_coef_reg;
    logic signed [COEF_W-1:0] filter_feedback_reg, filter_input_reg;
    logic signed [COEF_W-1:0] drive_high_reg, drive_low_reg;
    fvp_ctrl_t                ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg            <= '0;
            integral_coef_reg   <= '0;
            derivative_coef_reg <= '0;
            filter_feedback_reg <= '0;
            filter_input_reg    <= '0;
            drive_high_reg      <= DRIVE_HIGH_RST;
            drive_low_reg       <= DRIVE_LOW_RST;
        end else if (cfg_wr_en) begin
            case (fvp_cfg_t'(cfg_index))
                CFG_GAIN:            gain_reg            <= cfg_wdata;
                CFG_INTEGRAL_COEF:   integral_coef_reg   <= cfg_wdata;
                CFG_DERIVATIVE_COEF: derivative_coef_reg <= cfg_wdata;
                CFG_FILTER_FEEDBACK: filter_feedback_reg <= cfg_wdata;
                CFG_FILTER_INPUT:    filter_input_reg    <= cfg_wdata;
                CFG_DRIVE_HIGH:      drive_high_reg      <= cfg_wdata;
                CFG_DRIVE_LOW:       drive_low_reg       <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fvp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    fvp_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .s_measured      (s_measured),
        .s_setpoint      (s_setpoint),
        .s_enable        (s_enable),
        .gain            (gain_reg),
        .integral_coef   (integral_coef_reg),
        .derivative_coef (derivative_coef_reg),
        .filter_feedback (filter_feedback_reg),
        .filter_input    (filter_input_reg),
        .drive_high      (drive_high_reg),
        .drive_low       (drive_low_reg),
        .m_drive         (m_drive),
        .m_p_term        (m_p_term),
        .m_i_term        (m_i_term),
        .m_d_term        (m_d_term)
    );

endmodule

>>> rtl/fvp_checker.sv
// port-level checks for the filtered velocity pid unit, bound to the top level
// depends on fvp_pkg and filtered_velocity_pid_unit
`timescale 1ns / 1ps

module fvp_checker
    import fvp_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [COEF_W-1:0] m_drive
);

    // an accepted item keeps the input closed for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted item");

    // no result can be produced the cycle right after an item enters
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared one cycle after acceptance");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drive)))
        else $error("stalled result dropped or changed");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind filtered_velocity_pid_unit fvp_checker u_fvp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_drive (m_drive)
);

>>> sim/tb_top.sv
// self-checking testbench for filtered_velocity_pid_unit: directed and random samples,
// register sweeps and random handshake stalls, checked against a cycle-free predictor
// depends on fvp_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb_top
    import fvp_pkg::*;
();

    localparam int SW          = DEFAULT_SAMPLE_WIDTH;
    localparam int Q_ONE       = 65536;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 58;

    // register set flavors
    localparam int CK_MODERATE = 0;
    localparam int CK_MAX      = 1;
    localparam int CK_MIN      = 2;
    localparam int CK_CROSSED  = 3;
    localparam int CK_RAISED   = 4;
    localparam int CK_RANDOM   = 5;
    localparam int CK_LARGE    = 6;

    typedef struct {
        logic signed [COEF_W-1:0] drive;
        logic signed [COEF_W-1:0] p_term;
        logic signed [COEF_W-1:0] i_term;
        logic signed [COEF_W-1:0] d_term;
    } drive_terms_t;

    class pid_drive_checker;
        longint gain, integral_coef, derivative_coef, filter_fb, filter_in;
        longint drive_high, drive_low;
        longint last_error, filt_prev, filt_prev2, drive_hold;
        drive_terms_t pending_drives[$];
        int errors;

        function new();
            gain            = 0;
            integral_coef   = 0;
            derivative_coef = 0;
            filter_fb       = 0;
            filter_in       = 0;
            drive_high      = 6553600;
            drive_low       = 0;
            last_error      = 0;
            filt_prev       = 0;
            filt_prev2      = 0;
            drive_hold      = 0;
            errors          = 0;
        endfunction

        function longint clip_word(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void write_reg(fvp_cfg_t idx, logic signed [COEF_W-1:0] v);
            case (idx)
                CFG_GAIN:            gain            = longint'(v);
                CFG_INTEGRAL_COEF:   integral_coef   = longint'(v);
                CFG_DERIVATIVE_COEF: derivative_coef = longint'(v);
                CFG_FILTER_FEEDBACK: filter_fb       = longint'(v);
                CFG_FILTER_INPUT:    filter_in       = longint'(v);
                CFG_DRIVE_HIGH:      drive_high      = longint'(v);
                CFG_DRIVE_LOW:       drive_low       = longint'(v);
                default: ;
            endcase
        endfunction

        // advance the controller by one sample and queue the result it owes
        function void take_sample(logic signed [SW-1:0] meas, logic signed [SW-1:0] sp,
                                  logic en);
            longint err, filt, p, i, d, drv;
            drive_terms_t exp_res;
            err  = longint'(sp) - longint'(meas);
            filt = ((filter_fb * filt_prev) >>> COEF_FRAC)
                 + ((filter_in * clip_word(err + last_error)) >>> SAMPLE_FRAC);
            filt = clip_word(filt);
            p = 0;
            i = 0;
            d = 0;
            drv = 0;
            if (en) begin
                p = clip_word((gain * clip_word(err - last_error)) >>> SAMPLE_FRAC);
                i = clip_word((integral_coef * clip_word(err)) >>> SAMPLE_FRAC);
                d = clip_word((derivative_coef * clip_word(filt - 2 * filt_prev + filt_prev2))
                              >>> COEF_FRAC);
                drv = clip_word(drive_hold + p + i + d);
            end
            // high limit is checked first: with crossed limits a drive above it takes the high limit, else the low
            if (drv > drive_high) begin
                drv = drive_high;
            end else if (drv < drive_low) begin
                drv = drive_low;
            end
            last_error = err;
            filt_prev2 = filt_prev;
            filt_prev  = filt;
            drive_hold = drv;
            exp_res.drive  = drv[COEF_W-1:0];
            exp_res.p_term = p[COEF_W-1:0];
            exp_res.i_term = i[COEF_W-1:0];
            exp_res.d_term = d[COEF_W-1:0];
            pending_drives.push_back(exp_res);
        endfunction

        function void cmp_field(string name, logic signed [COEF_W-1:0] exp_v,
                                logic signed [COEF_W-1:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void match_result(logic signed [COEF_W-1:0] drv, logic signed [COEF_W-1:0] p,
                                   logic signed [COEF_W-1:0] i, logic signed [COEF_W-1:0] d);
            drive_terms_t exp_res;
            if (pending_drives.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none got drive %0d", $time, drv);
            end else begin
                exp_res = pending_drives.pop_front();
                cmp_field("drive", exp_res.drive, drv);
                cmp_field("p_term", exp_res.p_term, p);
                cmp_field("i_term", exp_res.i_term, i);
                cmp_field("d_term", exp_res.d_term, d);
            end
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction
    endclass

    logic                     aclk       = 1'b0;
    logic                     aresetn    = 1'b0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic signed [SW-1:0]     s_measured = '0;
    logic signed [SW-1:0]     s_setpoint = '0;
    logic                     s_enable   = 1'b0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic signed [COEF_W-1:0] m_drive;
    logic signed [COEF_W-1:0] m_p_term;
    logic signed [COEF_W-1:0] m_i_term;
    logic signed [COEF_W-1:0] m_d_term;
    logic                     cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [COEF_W-1:0]        cfg_wdata  = '0;

    pid_drive_checker chk = new();

    logic [COEF_W-1:0] cfg_set [7];
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int target   = 0;
    int quiet_cycles = 0;

    filtered_velocity_pid_unit #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_measured(s_measured),
        .s_setpoint(s_setpoint),
        .s_enable  (s_enable),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_drive   (m_drive),
        .m_p_term  (m_p_term),
        .m_i_term  (m_i_term),
        .m_d_term  (m_d_term),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // note register writes and samples, check results, all on pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                chk.write_reg(fvp_cfg_t'(cfg_index), cfg_wdata);
            end
            if (m_valid && m_ready) begin
                chk.match_result(m_drive, m_p_term, m_i_term, m_d_term);
            end
            if (s_valid && s_ready) begin
                chk.take_sample(s_measured, s_setpoint, s_enable);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout at %0t with %0d results outstanding", $time, chk.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    function automatic logic [COEF_W-1:0] spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic void fill_cfg(int kind);
        fvp_cfg_t ix;
        cfg_set[CFG_GAIN]            = spread(4 * Q_ONE);
        cfg_set[CFG_INTEGRAL_COEF]   = spread(Q_ONE);
        cfg_set[CFG_DERIVATIVE_COEF] = spread(2 * Q_ONE);
        cfg_set[CFG_FILTER_FEEDBACK] = spread(Q_ONE);
        cfg_set[CFG_FILTER_INPUT]    = spread(Q_ONE / 2);
        cfg_set[CFG_DRIVE_HIGH]      = 100 * Q_ONE;
        cfg_set[CFG_DRIVE_LOW]       = -100 * Q_ONE;
        case (kind)
            CK_MAX, CK_MIN: begin
                ix = ix.first();
                repeat (ix.num()) begin
                    cfg_set[ix] = (kind == CK_MAX) ? 32'h7fff_ffff : 32'h8000_0000;
                    ix = ix.next();
                end
                cfg_set[CFG_DRIVE_HIGH] = 32'h7fff_ffff;
                cfg_set[CFG_DRIVE_LOW]  = 32'h8000_0000;
            end
            CK_CROSSED: begin
                cfg_set[CFG_DRIVE_HIGH] = -10 * Q_ONE;
                cfg_set[CFG_DRIVE_LOW]  = 10 * Q_ONE;
            end
            CK_RAISED: begin
                // zero drive is outside the window, so disabled samples clamp up
                cfg_set[CFG_DRIVE_HIGH] = 50 * Q_ONE;
                cfg_set[CFG_DRIVE_LOW]  = 5 * Q_ONE;
            end
            CK_RANDOM: begin
                ix = ix.first();
                repeat (ix.num()) begin
                    cfg_set[ix] = $urandom;
                    ix = ix.next();
                end
            end
            CK_LARGE: begin
                cfg_set[CFG_GAIN]            = spread(1 << 28);
                cfg_set[CFG_INTEGRAL_COEF]   = spread(1 << 28);
                cfg_set[CFG_DERIVATIVE_COEF] = spread(1 << 28);
                cfg_set[CFG_FILTER_INPUT]    = spread(1 << 28);
                cfg_set[CFG_DRIVE_HIGH]      = 32'h7fff_ffff;
                cfg_set[CFG_DRIVE_LOW]       = 32'h8000_0000;
            end
            default: ;
        endcase
    endfunction

    task automatic load_registers(int kind);
        fvp_cfg_t ix;
        fill_cfg(kind);
        ix = ix.first();
        repeat (ix.num()) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ix;
            cfg_wdata <= cfg_set[ix];
            @(posedge aclk);
            ix = ix.next();
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic signed [SW-1:0] meas, logic signed [SW-1:0] sp, logic en);
        int gap;
        gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_measured <= meas;
        s_setpoint <= sp;
        s_enable   <= en;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    task automatic send_random();
        int style, meas, sp;
        logic en;
        style = $urandom_range(0, 9);
        en = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 15) == 0) begin
            target = int'($urandom_range(0, 65535)) - 32768;
        end
        if (style <= 4) begin
            // controller tracking a setpoint with a small error
            sp = target;
            meas = target + int'($urandom_range(0, 1024)) - 512;
            if (meas > 32767) begin
                meas = 32767;
            end else if (meas < -32768) begin
                meas = -32768;
            end
        end else if (style <= 7) begin
            sp = int'($urandom_range(0, 65535)) - 32768;
            meas = int'($urandom_range(0, 65535)) - 32768;
        end else if (style == 8) begin
            sp = pick_extreme();
            meas = pick_extreme();
        end else begin
            sp = int'($urandom_range(0, 65535)) - 32768;
            meas = int'($urandom_range(0, 65535)) - 32768;
            en = 1'b0;
        end
        send_sample(meas[SW-1:0], sp[SW-1:0], en);
    endtask

    // stop offering items and let every owed result come out
    task automatic settle_outputs();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk.pending() != 0);
        repeat (12) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: zero gains, drive window 0..100
        send_sample(16'sd0, 16'sd256, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        settle_outputs();

        // field extremes, floor rounding of small negative errors, disabled samples
        load_registers(CK_MODERATE);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 1'b1);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(16'sd32767, 16'sd32767, 1'b1);
        send_sample(-16'sd32768, -16'sd32768, 1'b1);
        send_sample(16'sd1, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd100, -16'sd100, 1'b0);
        send_sample(-16'sd1, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b0);
        settle_outputs();

        // full-scale coefficients: term, filter, second difference and sum saturation
        load_registers(CK_MAX);
        send_sample(-16'sd32768, 16'sd32767, 1'b1);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 1'b1);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(-16'sd32768, 16'sd32767, 1'b1);
        settle_outputs();

        // crossed limits, enabled and disabled
        load_registers(CK_CROSSED);
        send_sample(16'sd0, 16'sd512, 1'b1);
        send_sample(16'sd512, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        settle_outputs();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            automatic int kinds [N_PHASES] = '{CK_MODERATE, CK_CROSSED, CK_MAX,
                                               CK_RAISED, CK_MIN, CK_RANDOM,
                                               CK_LARGE, CK_MODERATE, CK_RANDOM};
            load_registers(kinds[phase]);
            tx_gaps = (phase % 3 != 2) && (phase != 6);
            rx_gaps = (phase % 3 != 1) && (phase != 6);
            // the receiver stops for a while mid-burst so the input backs up
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == PHASE_ITEMS / 2) begin
                    settle_outputs();
                end
                send_random();
            end
            settle_outputs();
        end

        if (chk.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, chk.pending());
            chk.errors++;
        end
        if (chk.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
